/* rtl/core/jac3_pkg.sv */
// Package for the 3x3 symmetric Jacobi eigen-solver.
// Holds payload structs, state codes, controller/datapath command structs and the arctan table.
// No dependencies.
package jac3_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW = 5;
    localparam int AccW = 48;
    localparam logic [StepW-1:0] LastStep = StepW'(((CordicSteps < 32) ? CordicSteps : 32) - 1);
    localparam logic signed [AccW-1:0] HalfPi = 48'sd1686629713;
    localparam logic signed [AccW-1:0] GainInv = 48'sd652032874;
    localparam logic [5:0] MaxSweepsReset = 6'd50;

    typedef enum logic [1:0] {
        REG_MAX_SWEEPS = 2'd0,
        REG_TOLERANCE  = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
        logic signed [31:0] a22;
    } t_in_item;

    typedef struct packed {
        logic signed [33:0] eigenvalue;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
        logic [1:0]         pair_index;
        logic               converged;
        logic               last;
    } t_out_item;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CHECK  = 10'b0000000010,
        S_VSETUP = 10'b0000000100,
        S_VEC    = 10'b0000001000,
        S_ROT    = 10'b0000010000,
        S_PROD   = 10'b0000100000,
        S_UPD    = 10'b0001000000,
        S_SORT   = 10'b0010000000,
        S_EMIT   = 10'b0100000000,
        S_SUM    = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic       load;
        logic       sum;
        logic       vsetup;
        logic       vinit;
        logic       vstep;
        logic       rsetup;
        logic       rstep;
        logic       prod;
        logic [2:0] upd;
        logic [1:0] pair;
        logic [StepW-1:0] step;
        logic       sort;
        logic [1:0] sort_phase;
        logic       emit;
        logic [1:0] rank;
    } t_cmd;

    typedef struct packed {
        logic off_ok;
    } t_status;

    function automatic logic signed [AccW-1:0] atan_lut(input logic [StepW-1:0] k);
        logic signed [AccW-1:0] r;
        begin
            case (k)
                5'd0: r = 48'sd843314856;
                5'd1: r = 48'sd497837829;
                5'd2: r = 48'sd263043836;
                5'd3: r = 48'sd133525158;
                5'd4: r = 48'sd67021686;
                5'd5: r = 48'sd33543515;
                5'd6: r = 48'sd16775850;
                5'd7: r = 48'sd8388437;
                5'd8: r = 48'sd4194282;
                5'd9: r = 48'sd2097149;
                5'd31: r = '0;
                default: r = 48'sd1 <<< (30 - k);
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/core/jac3_datapath.sv */
// Datapath of the Jacobi eigen-solver: working matrix, eigenvectors, CORDIC and sorter.
// Depends on jac3_pkg; driven by jac3_ctrl through t_cmd.
module jac3_datapath import jac3_pkg::*; (
    input  logic      i_clk,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic [15:0] i_tol,
    output t_status   o_status,
    output t_out_item o_item
);

    logic signed [39:0] r_d [3];
    logic signed [39:0] r_o [3];
    logic signed [17:0] r_v [9];
    logic signed [AccW-1:0] r_x, r_y, r_z;
    logic               r_zero;
    logic signed [17:0] r_c, r_s;
    logic signed [17:0] r_cc, r_ss, r_sc2;
    logic signed [41:0] r_sum;
    logic signed [39:0] r_val [3];
    logic [1:0] r_ord [3];
    logic signed [39:0] r_mii, r_mjj, r_mij, r_aik, r_ajk;
    logic signed [79:0] r_p [6];
    logic signed [39:0] r_vi [3];
    logic signed [39:0] r_vj [3];

    logic [1:0] pi_, pj_, pk_, pij, pik, pjk;

    always_comb begin
        case (i_cmd.pair)
            2'd0: begin pi_ = 2'd0; pj_ = 2'd1; end
            2'd1: begin pi_ = 2'd0; pj_ = 2'd2; end
            default: begin pi_ = 2'd1; pj_ = 2'd2; end
        endcase
        pk_ = 2'd3 - pi_ - pj_;
        pij = pi_ + pj_ - 2'd1;
        pik = pi_ + pk_ - 2'd1;
        pjk = pj_ + pk_ - 2'd1;
    end

    function automatic logic signed [39:0] rsat40(input logic signed [79:0] x);
        logic signed [79:0] t;
        begin
            t = (x + 80'sd32768) >>> 16;
            if (t > 80'sd549755813887) return 40'sh7fffffffff;
            if (t < -80'sd549755813888) return 40'sh8000000000;
            return t[39:0];
        end
    endfunction

    function automatic logic signed [17:0] rsat18(input logic signed [79:0] x);
        logic signed [79:0] t;
        begin
            t = (x + 80'sd32768) >>> 16;
            if (t > 80'sd131071) return 18'sh1ffff;
            if (t < -80'sd131072) return 18'sh20000;
            return t[17:0];
        end
    endfunction

    function automatic logic signed [17:0] rcs(input logic signed [AccW-1:0] x);
        logic signed [AccW-1:0] t;
        begin
            t = (x + 48'sd8192) >>> 14;
            if (t > 48'sd65536) return 18'sd65536;
            if (t < -48'sd65536) return -18'sd65536;
            return t[17:0];
        end
    endfunction

    function automatic logic signed [40:0] abs41(input logic signed [39:0] x);
        logic signed [40:0] t;
        begin
            t = 41'(x);
            return t[40] ? -t : t;
        end
    endfunction

    logic signed [AccW-1:0] dx, dy, vy0, vx0;
    logic [1:0] vb;
    logic signed [15:0] vo [3];
    logic signed [17:0] vsel;
    logic signed [18:0] vr;
    logic signed [39:0] ev;

    always_comb begin
        dx = r_x >>> i_cmd.step;
        dy = r_y >>> i_cmd.step;
        vy0 = AccW'(r_mij) <<< 1;
        vx0 = AccW'(r_mjj) - AccW'(r_mii);
        vb = r_ord[i_cmd.rank];
        for (int n = 0; n < 3; n++) begin
            vsel = r_v[vb*3 + n];
            vr = (19'(vsel) + 19'sd2) >>> 2;
            if (vr > 19'sd32767) vo[n] = 16'sh7fff;
            else if (vr < -19'sd32768) vo[n] = 16'sh8000;
            else vo[n] = vr[15:0];
        end
        ev = r_val[i_cmd.rank];
        o_item.eigenvalue = (ev > 40'sd8589934591) ? 34'sh1ffffffff :
                            (ev < -40'sd8589934592) ? 34'sh200000000 : ev[33:0];
        o_item.vec_x = vo[0];
        o_item.vec_y = vo[1];
        o_item.vec_z = vo[2];
        o_item.pair_index = i_cmd.rank;
        o_item.converged = 1'b0;
        o_item.last = (i_cmd.rank == 2'd2);
        o_status.off_ok = (r_sum <= 42'(i_tol));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d[0] <= 40'(i_item.a00);
            r_d[1] <= 40'(i_item.a11);
            r_d[2] <= 40'(i_item.a22);
            r_o[0] <= 40'(i_item.a01);
            r_o[1] <= 40'(i_item.a02);
            r_o[2] <= 40'(i_item.a12);
            for (int n = 0; n < 9; n++) r_v[n] <= (n % 4 == 0) ? 18'sd65536 : 18'sd0;
        end
        if (i_cmd.sum) begin
            r_sum <= 42'(abs41(r_o[0])) + 42'(abs41(r_o[1])) + 42'(abs41(r_o[2]));
        end
        if (i_cmd.vsetup) begin
            r_mii <= r_d[pi_];
            r_mjj <= r_d[pj_];
            r_mij <= r_o[pij];
            r_aik <= r_o[pik];
            r_ajk <= r_o[pjk];
        end
        if (i_cmd.vinit) begin
            // Pre-rotation into the right half plane; a zero angle holds the CORDIC.
            r_zero <= (vy0 == '0 && !vx0[AccW-1]);
            if (vy0 == '0 && !vx0[AccW-1]) begin
                r_x <= '0; r_y <= '0; r_z <= '0;
            end else if (vx0[AccW-1]) begin
                if (!vy0[AccW-1]) begin
                    r_x <= vy0; r_y <= -vx0; r_z <= HalfPi;
                end else begin
                    r_x <= -vy0; r_y <= vx0; r_z <= -HalfPi;
                end
            end else begin
                r_x <= vx0; r_y <= vy0; r_z <= '0;
            end
        end else if (i_cmd.vstep && !r_zero) begin
            if (r_y > 0) begin
                r_x <= r_x + dy; r_y <= r_y - dx; r_z <= r_z + atan_lut(i_cmd.step);
            end else begin
                r_x <= r_x - dy; r_y <= r_y + dx; r_z <= r_z - atan_lut(i_cmd.step);
            end
        end
        if (i_cmd.rsetup) begin
            r_x <= GainInv;
            r_y <= '0;
            r_z <= r_z >>> 1;
        end
        if (i_cmd.rstep) begin
            if (!r_z[AccW-1]) begin
                r_x <= r_x - dy; r_y <= r_y + dx; r_z <= r_z - atan_lut(i_cmd.step);
            end else begin
                r_x <= r_x + dy; r_y <= r_y - dx; r_z <= r_z + atan_lut(i_cmd.step);
            end
        end
        if (i_cmd.prod) begin
            r_c <= rcs(r_x);
            r_s <= rcs(r_y);
        end
        case (i_cmd.upd)
            3'd1: begin
                r_cc  <= rsat18(80'(r_c) * 80'(r_c) + 80'sd0);
                r_ss  <= rsat18(80'(r_s) * 80'(r_s));
                r_sc2 <= rsat18((80'(r_s) * 80'(r_c)) <<< 1);
                for (int n = 0; n < 3; n++) begin
                    r_vi[n] <= 40'(r_v[pi_*3 + n]);
                    r_vj[n] <= 40'(r_v[pj_*3 + n]);
                end
            end
            3'd2: begin
                r_p[0] <= 80'(r_cc) * 80'(r_mii);
                r_p[1] <= 80'(r_sc2) * 80'(r_mij);
                r_p[2] <= 80'(r_ss) * 80'(r_mjj);
                r_p[3] <= 80'(r_ss) * 80'(r_mii);
                r_p[4] <= 80'(r_cc) * 80'(r_mjj);
                r_p[5] <= 80'(r_c) * 80'(r_aik);
            end
            3'd3: begin
                r_d[pi_] <= rsat40(r_p[0] - r_p[1] + r_p[2]);
                r_d[pj_] <= rsat40(r_p[3] + r_p[1] + r_p[4]);
                r_o[pij] <= '0;
                r_p[0] <= 80'(r_s) * 80'(r_ajk);
                r_p[1] <= 80'(r_s) * 80'(r_aik);
                r_p[2] <= 80'(r_c) * 80'(r_ajk);
            end
            3'd4: begin
                r_o[pik] <= rsat40(r_p[5] - r_p[0]);
                r_o[pjk] <= rsat40(r_p[1] + r_p[2]);
                for (int n = 0; n < 3; n++) begin
                    r_v[pi_*3 + n] <= rsat18(80'(r_c) * 80'(r_vi[n]) - 80'(r_s) * 80'(r_vj[n]));
                    r_v[pj_*3 + n] <= rsat18(80'(r_s) * 80'(r_vi[n]) + 80'(r_c) * 80'(r_vj[n]));
                end
            end
            default: ;
        endcase
        if (i_cmd.sort) begin
            case (i_cmd.sort_phase)
                2'd0: begin
                    r_val[0] <= r_d[0]; r_val[1] <= r_d[1]; r_val[2] <= r_d[2];
                    r_ord[0] <= 2'd0; r_ord[1] <= 2'd1; r_ord[2] <= 2'd2;
                end
                2'd1: begin
                    if (r_val[1] < r_val[0] && !(r_val[2] < r_val[1])) begin
                        r_val[0] <= r_val[1]; r_val[1] <= r_val[0];
                        r_ord[0] <= r_ord[1]; r_ord[1] <= r_ord[0];
                    end else if (r_val[2] < r_val[0] &&
                                 (r_val[2] < r_val[1] || !(r_val[1] < r_val[0]))) begin
                        r_val[0] <= r_val[2]; r_val[2] <= r_val[0];
                        r_ord[0] <= r_ord[2]; r_ord[2] <= r_ord[0];
                    end
                end
                default: begin
                    if (r_val[2] < r_val[1]) begin
                        r_val[1] <= r_val[2]; r_val[2] <= r_val[1];
                        r_ord[1] <= r_ord[2]; r_ord[2] <= r_ord[1];
                    end
                end
            endcase
        end
    end

endmodule

/* rtl/core/jac3_ctrl.sv */
// Controller of the Jacobi eigen-solver: sweep, pair and CORDIC step sequencing.
// Depends on jac3_pkg; commands jac3_datapath.
module jac3_ctrl import jac3_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic [5:0] i_max_sweeps,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_strobe,
    output logic    o_conv
);

    t_state r_state, n_state;
    logic [5:0] r_sweeps, n_sweeps;
    logic [1:0] r_pair, n_pair;
    logic [StepW-1:0] r_step, n_step;
    logic [2:0] r_sub, n_sub;
    logic r_rot, n_rot;
    logic r_conv, n_conv;
    logic [1:0] r_rank, n_rank;

    always_comb begin
        n_state = r_state; n_sweeps = r_sweeps; n_pair = r_pair; n_step = r_step;
        n_sub = r_sub; n_rot = r_rot; n_conv = r_conv; n_rank = r_rank;
        o_cmd = '0;
        o_cmd.pair = r_pair;
        o_cmd.step = r_step;
        o_cmd.rank = r_rank;
        o_cmd.sort_phase = r_sub[1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SUM; n_sweeps = '0; n_conv = 1'b0;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.off_ok) begin
                    n_conv = 1'b1; n_state = S_SORT; n_sub = '0;
                end else if (r_sweeps >= i_max_sweeps) begin
                    n_state = S_SORT; n_sub = '0;
                end else begin
                    n_pair = 2'd0; n_state = S_VSETUP;
                end
            end
            S_VSETUP: begin
                o_cmd.vsetup = 1'b1;
                n_step = '0; n_rot = 1'b0; n_state = S_VEC;
            end
            S_VEC: begin
                // First cycle loads and pre-rotates; then one CORDIC step a cycle.
                if (!r_rot) begin
                    o_cmd.vinit = 1'b1;
                    n_rot = 1'b1;
                end else begin
                    o_cmd.vstep = 1'b1;
                    if (r_step == LastStep) begin
                        n_state = S_ROT; n_step = '0; n_rot = 1'b0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_ROT: begin
                if (!r_rot) begin
                    o_cmd.rsetup = 1'b1; n_rot = 1'b1;
                end else begin
                    o_cmd.rstep = 1'b1;
                    if (r_step == LastStep) begin
                        n_state = S_PROD;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_sub = 3'd1; n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = r_sub;
                if (r_sub == 3'd4) begin
                    if (r_pair == 2'd2) begin
                        n_sweeps = r_sweeps + 1'b1; n_state = S_SUM;
                    end else begin
                        n_pair = r_pair + 1'b1; n_state = S_VSETUP;
                    end
                end else begin
                    n_sub = r_sub + 1'b1;
                end
            end
            S_SORT: begin
                o_cmd.sort = 1'b1;
                if (r_sub == 3'd2) begin
                    n_state = S_EMIT; n_rank = '0;
                end else begin
                    n_sub = r_sub + 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (r_rank == 2'd2) n_state = S_IDLE;
                else n_rank = r_rank + 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_EMIT);
    assign o_conv = r_conv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_sweeps <= '0; r_pair <= '0; r_step <= '0;
            r_sub <= '0; r_rot <= 1'b0; r_conv <= 1'b0; r_rank <= '0;
        end else begin
            r_state <= n_state; r_sweeps <= n_sweeps; r_pair <= n_pair; r_step <= n_step;
            r_sub <= n_sub; r_rot <= n_rot; r_conv <= n_conv; r_rank <= n_rank;
        end
    end

endmodule

/* rtl/core/jacobi_eigen_3x3_symmetric_unit.sv */
// Each sweep runs on the one shared CORDIC unit, one step a cycle; a new item is taken
// only from idle, and busy stays high for the whole run.
// Results: three beats on consecutive cycles, one per eigenpair, strobed by o_valid.
// Reset is synchronous and active low; it clears the controller and the configuration registers.
// The receiver cannot stall the results.
module jacobi_eigen_3x3_symmetric_unit import jac3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_valid,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [5:0]  r_max_sweeps;
    logic [15:0] r_tol;
    t_cmd        cmd;
    t_status     status;
    t_out_item   dp_item;
    logic        conv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sweeps <= MaxSweepsReset;
            r_tol <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MAX_SWEEPS) r_max_sweeps <= i_cfg_data[5:0];
            else if (i_cfg_idx == REG_TOLERANCE) r_tol <= i_cfg_data;
        end
    end

    jac3_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_max_sweeps(r_max_sweeps),
        .i_status(status), .o_cmd(cmd), .o_busy(busy), .o_strobe(o_valid), .o_conv(conv)
    );

    jac3_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_item(i_item), .i_tol(r_tol),
        .o_status(status), .o_item(dp_item)
    );

    always_comb begin
        o_item = dp_item;
        o_item.converged = conv;
    end

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe outside a run");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.last) |=> !busy) else $error("run did not end after last");
    a_rank_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.last) |=> o_valid) else $error("results not consecutive");

endmodule
